### hw/rtl/lagged_velocity_correlation_accumulator_assert.svh
// Assertion macros for the lagged velocity correlation accumulator.
// Used by lvca_back.sv and the top level; no other dependencies.
`ifndef LAGGED_VELOCITY_CORRELATION_ACCUMULATOR_ASSERT_SVH
`define LAGGED_VELOCITY_CORRELATION_ACCUMULATOR_ASSERT_SVH
// implication checked every clock outside reset
`define LVCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lvca check failed");
// next-cycle implication
`define LVCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lvca check failed");
`endif

### hw/rtl/lvca_pkg.sv
// Shared types and constants for the lagged velocity correlation accumulator.
// No dependencies.
package lvca_pkg;
  localparam int LineLen = 64;
  localparam int Planes = 16;
  localparam int PosW = 6;
  localparam int PlaneW = 4;
  localparam int SumW = 56;
  localparam int BinAw = 1 + PlaneW + PosW + 2;
  localparam int BinDepth = 2 * Planes * LineLen * 4;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ACC = 2'd1,
    CMD_READ = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic [PosW-1:0] position;
    logic [PlaneW-1:0] plane;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic slip_flag;
    logic [1:0] component;
    logic [PosW-1:0] lag;
    logic point_class;
    logic read_ok;
    logic acc_ok;
  } item_t;

  typedef struct packed {
    logic [SumW-1:0] bin_sum;
    logic read_valid;
    logic saturated;
  } res_t;
endpackage

### hw/rtl/lvca_front.sv
// Front end: accepts classified input beats and holds them in a 2-entry queue.
// Depends on lvca_pkg.
module lvca_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  lvca_pkg::item_t in_item,
  output logic q_valid,
  input  logic q_take,
  output lvca_pkg::item_t q_item
);
  lvca_pkg::item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push_ok;
  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rp_r];
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, q_take && q_valid};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wp_r <= ~wp_r;
      if (q_take && q_valid) rp_r <= ~rp_r;
    end
    if (push_ok) buf_r[wp_r] <= in_item;
  end
endmodule

### hw/rtl/lvca_back.sv
// Back end: line store, bin memory and the pair sequencer with saturating add.
// Depends on lvca_pkg and the assertion header.
`include "lagged_velocity_correlation_accumulator_assert.svh"
module lvca_back (
  input  logic clk,
  input  logic rst_n,
  input  logic [6:0] cfg_len,
  input  logic q_valid,
  output logic q_take,
  input  lvca_pkg::item_t q_item,
  output logic res_valid,
  input  logic res_take,
  output lvca_pkg::res_t res
);
  typedef enum logic [6:0] {
    S_CLR_INIT = 7'b0000001, S_IDLE = 7'b0000010, S_RD = 7'b0000100,
    S_PAIR = 7'b0001000, S_MUL = 7'b0010000, S_ADD = 7'b0100000,
    S_CLR = 7'b1000000
  } st_t;
  localparam int AW = lvca_pkg::BinAw;
  localparam logic signed [lvca_pkg::SumW-1:0] SMAX = {1'b0, {(lvca_pkg::SumW-1){1'b1}}};
  localparam logic signed [lvca_pkg::SumW-1:0] SMIN = {1'b1, {(lvca_pkg::SumW-1){1'b0}}};

  st_t st_r;
  logic [48:0] line_mem [lvca_pkg::LineLen];
  logic signed [lvca_pkg::SumW-1:0] bin_mem [lvca_pkg::BinDepth];
  logic [48:0] pi_r, pj_r;
  logic signed [lvca_pkg::SumW-1:0] bin_rd_r;
  logic signed [31:0] prod_r;
  logic [AW-1:0] addr_r, clr_r;
  logic [lvca_pkg::PosW-1:0] i_r, j_r, lagc_r;
  logic [1:0] c_r;
  logic [6:0] n_r;
  logic [lvca_pkg::PlaneW-1:0] plane_r;
  logic sat_r, rv_r;
  lvca_pkg::res_t res_r;
  logic busy_res;
  logic rv_set;
  lvca_pkg::item_t it_r;
  logic signed [15:0] a16, b16;
  logic signed [lvca_pkg::SumW:0] sum_w;
  logic signed [lvca_pkg::SumW-1:0] sum_sat;
  logic sat_hit;
  logic [6:0] nclamp;
  logic last_c, last_j, last_i;

  assign res_valid = rv_r;
  assign res = res_r;
  assign busy_res = rv_r && !res_take;
  assign q_take = (st_r == S_IDLE) && q_valid && !busy_res;
  assign nclamp = (cfg_len > 7'(lvca_pkg::LineLen)) ? 7'(lvca_pkg::LineLen) : cfg_len;

  always_comb begin
    unique case (c_r)
      2'd0: begin a16 = pi_r[48:33]; b16 = pj_r[48:33]; end
      2'd1: begin a16 = pi_r[32:17]; b16 = pj_r[32:17]; end
      default: begin a16 = pi_r[16:1]; b16 = pj_r[16:1]; end
    endcase
    sum_w = {bin_rd_r[lvca_pkg::SumW-1], bin_rd_r} + (lvca_pkg::SumW+1)'(prod_r);
    sat_hit = sum_w[lvca_pkg::SumW] != sum_w[lvca_pkg::SumW-1];
    sum_sat = !sat_hit ? sum_w[lvca_pkg::SumW-1:0] :
              (sum_w[lvca_pkg::SumW] ? SMIN : SMAX);
  end
  assign last_c = (c_r == 2'd2);
  assign last_j = ({1'b0, j_r} == n_r - 7'd1);
  assign last_i = ({1'b0, i_r} == n_r - 7'd1);

  // result register loads: read, clear end, load, empty accumulate, accumulate end
  assign rv_set = (st_r == S_RD) ||
                  ((st_r == S_CLR) && (clr_r == AW'(lvca_pkg::BinDepth - 1))) ||
                  (q_take && (q_item.cmd == lvca_pkg::CMD_LOAD ||
                              (q_item.cmd == lvca_pkg::CMD_ACC &&
                               !(q_item.acc_ok && nclamp != 7'd0)))) ||
                  ((st_r == S_ADD) && last_c && last_j && last_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR_INIT;
      clr_r <= '0;
      sat_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      if (rv_set) rv_r <= 1'b1;
      else if (rv_r && res_take) rv_r <= 1'b0;
      unique case (st_r)
        S_CLR_INIT, S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(lvca_pkg::BinDepth - 1)) begin
            st_r <= S_IDLE;
            if (st_r == S_CLR) begin
              res_r <= '{bin_sum: '0, read_valid: 1'b0, saturated: 1'b0};
            end
          end
        end
        S_IDLE: begin
          if (q_take) begin
            it_r <= q_item;
            unique case (q_item.cmd)
              lvca_pkg::CMD_LOAD: begin
                line_mem[q_item.position] <= {q_item.vel_x, q_item.vel_y,
                                              q_item.vel_z, q_item.slip_flag};
                res_r <= '{bin_sum: '0, read_valid: 1'b0, saturated: sat_r};
              end
              lvca_pkg::CMD_READ: begin
                addr_r <= {q_item.point_class, q_item.plane, q_item.lag, q_item.component};
                st_r <= S_RD;
              end
              lvca_pkg::CMD_CLEAR: begin
                sat_r <= 1'b0;
                clr_r <= '0;
                st_r <= S_CLR;
              end
              default: begin
                if (q_item.acc_ok && nclamp != 7'd0) begin
                  n_r <= nclamp;
                  plane_r <= q_item.plane;
                  i_r <= '0; j_r <= '0; c_r <= '0; lagc_r <= '0;
                  st_r <= S_PAIR;
                end else begin
                  res_r <= '{bin_sum: '0, read_valid: 1'b0, saturated: sat_r};
                end
              end
            endcase
          end
        end
        S_RD: begin
          res_r <= '{bin_sum: it_r.read_ok ? bin_mem[addr_r] : '0,
                     read_valid: it_r.read_ok, saturated: sat_r};
          st_r <= S_IDLE;
        end
        S_PAIR: begin
          pi_r <= line_mem[i_r];
          pj_r <= line_mem[j_r];
          st_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= a16 * b16;
          addr_r <= {~pi_r[0], plane_r, lagc_r, c_r};
          bin_rd_r <= bin_mem[{~pi_r[0], plane_r, lagc_r, c_r}];
          st_r <= S_ADD;
        end
        default: begin
          if (sat_hit) sat_r <= 1'b1;
          if (!last_c) begin
            c_r <= c_r + 2'd1;
            st_r <= S_MUL;
          end else begin
            c_r <= '0;
            if (!last_j) begin
              j_r <= j_r + 1'b1;
              lagc_r <= ({1'b0, lagc_r} == n_r - 7'd1) ? '0 : lagc_r + 1'b1;
              st_r <= S_PAIR;
            end else if (!last_i) begin
              i_r <= i_r + 1'b1;
              j_r <= '0;
              lagc_r <= lvca_pkg::PosW'(n_r - 7'd1 - {1'b0, i_r});
              st_r <= S_PAIR;
            end else begin
              res_r <= '{bin_sum: '0, read_valid: 1'b0, saturated: sat_r | sat_hit};
              st_r <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_CLR_INIT || st_r == S_CLR) bin_mem[clr_r] <= '0;
    else if (st_r == S_ADD) bin_mem[addr_r] <= sum_sat;
  end

  `LVCA_ASSERT_IMP(a_take_idle, q_take, st_r == S_IDLE && !busy_res)
  `LVCA_ASSERT_NEXT(a_read_done, st_r == S_RD, rv_r && st_r == S_IDLE)
  `LVCA_ASSERT_IMP(a_rv_sat, rv_r && res_r.read_valid, res_r.saturated == sat_r)
endmodule

### hw/rtl/lagged_velocity_correlation_accumulator.sv
// Lagged velocity correlation accumulator: accepts command beats on a push/full
// queue port, returns one result beat per command on an empty/pop port.
// Load, read and clear are one beat in, one result out; beats pass a 2-entry
// input queue. After reset a clearing pass over all 8192 bins zeroes the bin
// memory; input is accepted (queued) but not executed until it ends. Config
// writes always taken. Load writes the line store and result when taken; Read
// registers the bin memory word into the result in S_RD. Accumulate: for line
// length n (clamped to 64), S_PAIR fetches each of the n*n pairs, then S_MUL
// and S_ADD read-modify-write the bin per component. Clear: one bin per cycle.
// When the receiver does not pop, the result register holds and the back end
// stops taking commands; the front queue then fills and raises full.
// Configuration (line length) must be written only while idle.
// Depends on lvca_pkg, lvca_front, lvca_back and the assertion header.
`include "lagged_velocity_correlation_accumulator_assert.svh"
module lagged_velocity_correlation_accumulator (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [1:0] in_cmd,
  input  logic [5:0] in_position,
  input  logic [3:0] in_plane,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_vel_z,
  input  logic in_slip_flag,
  input  logic [1:0] in_component,
  input  logic [5:0] in_lag,
  input  logic in_point_class,
  output logic out_empty,
  input  logic out_pop,
  output logic signed [55:0] out_bin_sum,
  output logic out_read_valid,
  output logic out_saturated,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [6:0] cfg_data
);
  lvca_pkg::item_t in_item, q_item;
  lvca_pkg::res_t res;
  logic q_valid, q_take, res_valid;
  logic [6:0] len_r;

  always_comb begin
    in_item.cmd = lvca_pkg::cmd_t'(in_cmd);
    in_item.position = in_position;
    in_item.plane = in_plane;
    in_item.vel_x = in_vel_x;
    in_item.vel_y = in_vel_y;
    in_item.vel_z = in_vel_z;
    in_item.slip_flag = in_slip_flag;
    in_item.component = in_component;
    in_item.lag = in_lag;
    in_item.point_class = in_point_class;
    in_item.read_ok = (in_component != 2'd3) && ({1'b0, in_plane} < 5'(lvca_pkg::Planes));
    in_item.acc_ok = ({1'b0, in_plane} < 5'(lvca_pkg::Planes));
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= 7'd64;
    else if (cfg_valid) len_r <= cfg_data;
  end

  lvca_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );
  lvca_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_len(len_r), .q_valid(q_valid),
    .q_take(q_take), .q_item(q_item), .res_valid(res_valid),
    .res_take(out_pop), .res(res)
  );

  assign out_empty = !res_valid;
  assign out_bin_sum = res.bin_sum;
  assign out_read_valid = res.read_valid;
  assign out_saturated = res.saturated;

  `LVCA_ASSERT_IMP(a_take_has_item, q_take, q_valid)
  `LVCA_ASSERT_IMP(a_nonread_zero, !out_empty && !out_read_valid, out_bin_sum == '0)
  `LVCA_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_bin_sum))
endmodule
